### src/two_level_bitmap_allocator_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the two-level bitmap allocator
// Clocked implication checks that vanish when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef TWO_LEVEL_BITMAP_ALLOCATOR_UNIT_ASSERT_SVH
`define TWO_LEVEL_BITMAP_ALLOCATOR_UNIT_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on the rising edge of clk outside reset.
`define TLBA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tlba assertion failed");
// Next-cycle implication.
`define TLBA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tlba assertion failed");
`else
`define TLBA_ASSERT_IMP(lbl, ante, cons)
`define TLBA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### src/tlba_pkg.sv
// ----------------------------------------------------------------------------
// tlba_pkg
// Shared constants and types of the two-level bitmap allocator.
// ----------------------------------------------------------------------------
package tlba_pkg;

    localparam int INDEX_W = 14;
    localparam int LIMIT_W = 15;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd16384;

    // Bit position inside one bitmap word; words are at most 64 bits wide.
    localparam int POS_W = 6;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef struct packed {
        logic             all_set;
        logic [POS_W-1:0] pos;
    } find_res_t;

endpackage

### src/tlba_find_clear.sv
// ----------------------------------------------------------------------------
// tlba_find_clear
// Finds the lowest clear bit of one bitmap word and flags a full word.
// ----------------------------------------------------------------------------
module tlba_find_clear
    import tlba_pkg::*;
#(
    parameter int WORD_BITS = 64
)
(
    input  logic [WORD_BITS-1:0] data_word,
    output find_res_t            res
);

    logic [WORD_BITS-1:0] free_bits;
    logic [WORD_BITS-1:0] lowest_free;
    logic [POS_W-1:0]     pos_enc;

    assign free_bits   = ~data_word;
    // Two's complement trick isolates the lowest free bit as a one-hot word.
    assign lowest_free = free_bits & (~free_bits + WORD_BITS'(1));

    always_comb
    begin
        pos_enc = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (lowest_free[i])
            begin
                pos_enc = pos_enc | POS_W'(i);
            end
        end
    end

    // A full word reports its top bit, which keeps a later set harmless.
    assign res.all_set = &data_word;
    assign res.pos     = res.all_set ? POS_W'(WORD_BITS - 1) : pos_enc;

endmodule

### src/two_level_bitmap_allocator_unit.sv
// Allocate: a header scan through one shared lowest-clear finder with one memory read per step,
// then a leaf read and check; each full header word skipped adds another header read and check.
// No new beat is taken until the response has been handed to the output register.
// Release: a leaf and header read, then a write that clears the slot's leaf and header bits.
// After reset a clearing pass writes zero to one leaf word a cycle, over all LEAF_COUNT leaf
// words (256 by default), with no input beat taken; bits_in_use resets to 16384.
// ----------------------------------------------------------------------------
// two_level_bitmap_allocator_unit
// Slot allocator over a two-level bitmap: header words mark full leaf words,
// leaf words mark slots in use. WORD_BITS must be a power of two.
// ----------------------------------------------------------------------------
`include "two_level_bitmap_allocator_unit_assert.svh"

module two_level_bitmap_allocator_unit
    import tlba_pkg::*;
#(
    parameter int MAX_SLOTS = 16384,
    parameter int WORD_BITS = 64
)
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               cfg_wr_en,
    input  logic [LIMIT_W-1:0] cfg_wr_data,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic               op,
    input  logic [INDEX_W-1:0] slot_index,

    output logic               out_valid,
    input  logic               out_stall,
    output logic [INDEX_W-1:0] granted_index,
    output logic               full_res
);

    localparam int LEAF_COUNT   = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int HEADER_COUNT = (LEAF_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int WB_LOG       = $clog2(WORD_BITS);
    localparam int LEAF_AW      = (LEAF_COUNT > 1) ? $clog2(LEAF_COUNT) : 1;
    localparam int HDR_AW       = (HEADER_COUNT > 1) ? $clog2(HEADER_COUNT) : 1;
    localparam int HDR_CW       = $clog2(HEADER_COUNT + 1);
    localparam int LFW          = HDR_AW + WB_LOG;
    localparam int SPAN         = WORD_BITS * WORD_BITS;
    localparam int BASE_W       = $clog2(HEADER_COUNT * SPAN + 1);
    localparam int W0           = (BASE_W > LIMIT_W) ? BASE_W : LIMIT_W;
    localparam int W            = (W0 > LFW + WB_LOG) ? W0 : LFW + WB_LOG;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HRD,
        ST_HCHK,
        ST_LRD,
        ST_LCHK,
        ST_REL_RD,
        ST_REL_WR
    } state_t;

    // Response wait shares the encoding space through a separate flag.
    state_t               state_reg, state_next;
    logic                 resp_reg, resp_next;
    logic [LEAF_AW-1:0]   clr_reg, clr_next;
    logic [HDR_CW-1:0]    h_reg, h_next;
    logic [W-1:0]         base_reg, base_next;
    logic [LFW-1:0]       leaf_reg, leaf_next;
    logic [WB_LOG-1:0]    chunk_reg, chunk_next;
    logic [INDEX_W-1:0]   slot_reg, slot_next;
    logic [INDEX_W-1:0]   res_index_reg, res_index_next;
    logic                 res_full_reg, res_full_next;
    logic [LIMIT_W-1:0]   bits_in_use_reg, bits_in_use_next;
    logic                 out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0]   granted_index_reg, granted_index_next;
    logic                 full_res_reg, full_res_next;

    logic [WORD_BITS-1:0] leaf_mem [LEAF_COUNT];
    logic [WORD_BITS-1:0] hdr_mem  [HEADER_COUNT];
    logic [WORD_BITS-1:0] leaf_rd_reg;
    logic [WORD_BITS-1:0] hdr_rd_reg;

    logic                 leaf_we;
    logic [LEAF_AW-1:0]   leaf_wr_addr;
    logic [WORD_BITS-1:0] leaf_wr_data;
    logic [LEAF_AW-1:0]   leaf_rd_addr;
    logic                 hdr_we;
    logic [HDR_AW-1:0]    hdr_wr_addr;
    logic [WORD_BITS-1:0] hdr_wr_data;
    logic [HDR_AW-1:0]    hdr_rd_addr;

    logic [WORD_BITS-1:0] find_word;
    find_res_t            find_res;

    logic [W-1:0]         limit_ext;
    logic [W-1:0]         limit_eff;
    logic [W-1:0]         slot_w;
    logic [LFW-1:0]       leaf_found;
    logic [W-1:0]         grant_w;
    logic [WORD_BITS-1:0] leaf_set_word;
    logic                 out_free;

    // One finder serves the header scan and the leaf search.
    assign find_word = (state_reg == ST_HCHK) ? hdr_rd_reg : leaf_rd_reg;

    tlba_find_clear #(
        .WORD_BITS (WORD_BITS)
    ) u_find (
        .data_word (find_word),
        .res       (find_res)
    );

    assign limit_ext  = W'(bits_in_use_reg);
    assign limit_eff  = (limit_ext > W'(MAX_SLOTS)) ? W'(MAX_SLOTS) : limit_ext;
    assign slot_w     = W'(slot_reg);
    assign leaf_found = {h_reg[HDR_AW-1:0], find_res.pos[WB_LOG-1:0]};
    assign grant_w    = W'({leaf_reg, find_res.pos[WB_LOG-1:0]});
    assign leaf_set_word = leaf_rd_reg | (WORD_BITS'(1) << find_res.pos);
    assign out_free   = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next         = state_reg;
        resp_next          = resp_reg;
        clr_next           = clr_reg;
        h_next             = h_reg;
        base_next          = base_reg;
        leaf_next          = leaf_reg;
        chunk_next         = chunk_reg;
        slot_next          = slot_reg;
        res_index_next     = res_index_reg;
        res_full_next      = res_full_reg;
        bits_in_use_next   = cfg_wr_en ? cfg_wr_data : bits_in_use_reg;
        out_valid_next     = out_valid_reg && out_stall;
        granted_index_next = granted_index_reg;
        full_res_next      = full_res_reg;

        leaf_we      = 1'b0;
        leaf_wr_addr = leaf_reg[LEAF_AW-1:0];
        leaf_wr_data = leaf_set_word;
        hdr_we       = 1'b0;
        hdr_wr_addr  = h_reg[HDR_AW-1:0];
        hdr_wr_data  = hdr_rd_reg | (WORD_BITS'(1) << chunk_reg);

        if (state_reg inside {ST_REL_RD, ST_REL_WR})
        begin
            leaf_rd_addr = slot_w[WB_LOG +: LEAF_AW];
            hdr_rd_addr  = slot_w[2 * WB_LOG +: HDR_AW];
        end
        else
        begin
            leaf_rd_addr = leaf_reg[LEAF_AW-1:0];
            hdr_rd_addr  = h_reg[HDR_AW-1:0];
        end

        if (resp_reg)
        begin
            if (out_free)
            begin
                out_valid_next     = 1'b1;
                granted_index_next = res_index_reg;
                full_res_next      = res_full_reg;
                resp_next          = 1'b0;
                state_next         = ST_IDLE;
            end
        end
        else
        begin
            case (state_reg)
                ST_CLEAR:
                begin
                    leaf_we      = 1'b1;
                    leaf_wr_addr = clr_reg;
                    leaf_wr_data = '0;
                    hdr_we       = ({1'b0, clr_reg} < (LEAF_AW + 1)'(HEADER_COUNT));
                    hdr_wr_addr  = clr_reg[HDR_AW-1:0];
                    hdr_wr_data  = '0;
                    clr_next     = clr_reg + LEAF_AW'(1);
                    if (clr_reg == LEAF_AW'(LEAF_COUNT - 1))
                    begin
                        state_next = ST_IDLE;
                    end
                end

                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        slot_next = slot_index;
                        h_next    = '0;
                        base_next = '0;
                        if (op == OP_RELEASE)
                        begin
                            state_next = ST_REL_RD;
                        end
                        else
                        begin
                            state_next = ST_HRD;
                        end
                    end
                end

                ST_HRD:
                begin
                    // Header words past the limit are never scanned.
                    if (base_reg >= limit_eff)
                    begin
                        res_index_next = '0;
                        res_full_next  = 1'b1;
                        resp_next      = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_HCHK;
                    end
                end

                ST_HCHK:
                begin
                    if (find_res.all_set)
                    begin
                        h_next     = h_reg + HDR_CW'(1);
                        base_next  = base_reg + W'(SPAN);
                        state_next = ST_HRD;
                    end
                    else if (W'(leaf_found) >= W'(LEAF_COUNT))
                    begin
                        res_index_next = '0;
                        res_full_next  = 1'b1;
                        resp_next      = 1'b1;
                    end
                    else
                    begin
                        leaf_next  = leaf_found;
                        chunk_next = find_res.pos[WB_LOG-1:0];
                        state_next = ST_LRD;
                    end
                end

                ST_LRD:
                begin
                    state_next = ST_LCHK;
                end

                ST_LCHK:
                begin
                    resp_next = 1'b1;
                    if (grant_w >= limit_eff)
                    begin
                        res_index_next = '0;
                        res_full_next  = 1'b1;
                    end
                    else
                    begin
                        leaf_we        = 1'b1;
                        hdr_we         = &leaf_set_word;
                        res_index_next = grant_w[INDEX_W-1:0];
                        res_full_next  = 1'b0;
                    end
                end

                ST_REL_RD:
                begin
                    state_next = ST_REL_WR;
                end

                ST_REL_WR:
                begin
                    if (slot_w < W'(MAX_SLOTS))
                    begin
                        leaf_we      = 1'b1;
                        leaf_wr_addr = slot_w[WB_LOG +: LEAF_AW];
                        leaf_wr_data = leaf_rd_reg &
                                       ~(WORD_BITS'(1) << slot_w[WB_LOG-1:0]);
                        hdr_we       = 1'b1;
                        hdr_wr_addr  = slot_w[2 * WB_LOG +: HDR_AW];
                        hdr_wr_data  = hdr_rd_reg &
                                       ~(WORD_BITS'(1) << slot_w[WB_LOG +: WB_LOG]);
                    end
                    res_index_next = slot_reg;
                    res_full_next  = 1'b0;
                    resp_next      = 1'b1;
                end

                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_CLEAR;
            resp_reg          <= 1'b0;
            clr_reg           <= '0;
            h_reg             <= '0;
            base_reg          <= '0;
            leaf_reg          <= '0;
            chunk_reg         <= '0;
            slot_reg          <= '0;
            res_index_reg     <= '0;
            res_full_reg      <= 1'b0;
            bits_in_use_reg   <= LIMIT_RESET;
            out_valid_reg     <= 1'b0;
            granted_index_reg <= '0;
            full_res_reg      <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            resp_reg          <= resp_next;
            clr_reg           <= clr_next;
            h_reg             <= h_next;
            base_reg          <= base_next;
            leaf_reg          <= leaf_next;
            chunk_reg         <= chunk_next;
            slot_reg          <= slot_next;
            res_index_reg     <= res_index_next;
            res_full_reg      <= res_full_next;
            bits_in_use_reg   <= bits_in_use_next;
            out_valid_reg     <= out_valid_next;
            granted_index_reg <= granted_index_next;
            full_res_reg      <= full_res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (leaf_we)
        begin
            leaf_mem[leaf_wr_addr] <= leaf_wr_data;
        end
        leaf_rd_reg <= leaf_mem[leaf_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (hdr_we)
        begin
            hdr_mem[hdr_wr_addr] <= hdr_wr_data;
        end
        hdr_rd_reg <= hdr_mem[hdr_rd_addr];
    end

    assign in_stall      = (state_reg != ST_IDLE) || resp_reg;
    assign out_valid     = out_valid_reg;
    assign granted_index = granted_index_reg;
    assign full_res      = full_res_reg;

    // A pending response goes out as soon as the output register frees up.
    `TLBA_ASSERT_NEXT(a_resp_delivered, resp_reg && out_free, out_valid && !resp_reg)
    // A full report never carries a slot number.
    `TLBA_ASSERT_IMP(a_full_zero_index, out_valid && full_res, granted_index == '0)
    // The header scan never examines a word beyond the header store.
    `TLBA_ASSERT_IMP(a_hdr_in_range, state_reg == ST_HCHK && !resp_reg,
                     {1'b0, h_reg} < (HDR_CW + 1)'(HEADER_COUNT))

endmodule
